FILE: design/crtc_pkg.sv
// Package for the character run classifier: class and kind codes, the result
// word layout, the fixed word list and the class and match functions.
// No dependencies.
package crtc_pkg;

  // Words kept for matching in the fixed word list (longest word).
  localparam int WORD_MAX     = 8;
  localparam int WORD_COUNT   = 33;
  localparam int MATCH_CHARS_DEF = 8;
  localparam int RUN_LEN_W    = 16;

  // Result queue depth and its level width.
  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_W    = $clog2(RES_DEPTH);
  localparam int RES_LEVEL_W  = $clog2(RES_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_SPACE   = 3'd0,
    CLS_TAB     = 3'd1,
    CLS_OPER    = 3'd2,
    CLS_PUNCT   = 3'd3,
    CLS_LETTER  = 3'd4,
    CLS_DIGIT   = 3'd5,
    CLS_CONTROL = 3'd6
  } class_t;

  typedef enum logic [1:0] {
    KIND_KEYWORD = 2'd0,
    KIND_TYPE    = 2'd1,
    KIND_OPER    = 2'd2,
    KIND_GENERIC = 2'd3
  } kind_t;

  // One result word as it waits in the queue.
  typedef struct packed {
    class_t                 char_class;
    kind_t                  group_kind;
    logic [RUN_LEN_W-1:0]   run_length;
    logic                   ends_line;
    logic                   last;
  } result_t;

  // Queue status seen by the run logic.
  typedef struct packed {
    logic [RES_LEVEL_W-1:0] level;
    logic                   room2;
  } fifo_status_t;

  // Word text is right-aligned: the last character sits in bits [7:0].
  typedef struct packed {
    logic [8*WORD_MAX-1:0] text;
    logic [3:0]            len;
    kind_t                 kind;
  } word_t;

  localparam word_t WORDS [WORD_COUNT] = '{
    '{"if",       4'd2, KIND_KEYWORD}, '{"else",     4'd4, KIND_KEYWORD},
    '{"for",      4'd3, KIND_KEYWORD}, '{"while",    4'd5, KIND_KEYWORD},
    '{"return",   4'd6, KIND_KEYWORD}, '{"switch",   4'd6, KIND_KEYWORD},
    '{"case",     4'd4, KIND_KEYWORD}, '{"break",    4'd5, KIND_KEYWORD},
    '{"continue", 4'd8, KIND_KEYWORD},
    '{"int",      4'd3, KIND_TYPE},    '{"float",    4'd5, KIND_TYPE},
    '{"double",   4'd6, KIND_TYPE},    '{"char",     4'd4, KIND_TYPE},
    '{"void",     4'd4, KIND_TYPE},    '{"bool",     4'd4, KIND_TYPE},
    '{"unsigned", 4'd8, KIND_TYPE},    '{"long",     4'd4, KIND_TYPE},
    '{"short",    4'd5, KIND_TYPE},
    '{"+",  4'd1, KIND_OPER}, '{"-",  4'd1, KIND_OPER}, '{"*",  4'd1, KIND_OPER},
    '{"/",  4'd1, KIND_OPER}, '{"%",  4'd1, KIND_OPER}, '{"=",  4'd1, KIND_OPER},
    '{"==", 4'd2, KIND_OPER}, '{"!=", 4'd2, KIND_OPER}, '{"<",  4'd1, KIND_OPER},
    '{">",  4'd1, KIND_OPER}, '{"<=", 4'd2, KIND_OPER}, '{">=", 4'd2, KIND_OPER},
    '{"&&", 4'd2, KIND_OPER}, '{"||", 4'd2, KIND_OPER}, '{"!",  4'd1, KIND_OPER}
  };

  // Character class of one byte.
  function automatic class_t classify(input logic [7:0] c);
    class_t cls;
    if (c == 8'd32) begin
      cls = CLS_SPACE;
    end else if (c == 8'd9) begin
      cls = CLS_TAB;
    end else if (c inside {"+", "-", "*", "/", "%", "&", "|", "^", "=", "<", ">", "!"}) begin
      cls = CLS_OPER;
    end else if (c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]}) begin
      cls = CLS_PUNCT;
    end else if (c inside {["A":"Z"], ["a":"z"]}) begin
      cls = CLS_LETTER;
    end else if (c inside {["0":"9"]}) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_CONTROL;
    end
    return cls;
  endfunction

  // Kind of a run given its first characters (index 0 first) and its length.
  // A word matches only when the lengths agree, so only written characters count.
  function automatic kind_t match_kind(input logic [WORD_MAX-1:0][7:0] chars,
                                       input logic [RUN_LEN_W-1:0]   count);
    kind_t k;
    logic  hit;
    int    pos;
    k = KIND_GENERIC;
    for (int w = 0; w < WORD_COUNT; w++) begin
      hit = (count == RUN_LEN_W'(WORDS[w].len));
      for (int i = 0; i < WORD_MAX; i++) begin
        if (i < int'(WORDS[w].len)) begin
          pos = int'(WORDS[w].len) - 1 - i;
          if (chars[i] != WORDS[w].text[pos*8 +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit && k == KIND_GENERIC) begin
        k = WORDS[w].kind;
      end
    end
    return k;
  endfunction

endpackage

FILE: design/crtc_char_if.sv
// Character channel: one text byte and its end-of-line flag per word.
// Depends on nothing.
interface crtc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink   (input valid, input ch, input line_end, output ready);
endinterface

FILE: design/crtc_group_if.sv
// Group channel: one closed run (class, kind, length, flags) per word.
// Depends on nothing.
interface crtc_group_if;
  logic        valid;
  logic        ready;
  logic [2:0]  char_class;
  logic [1:0]  group_kind;
  logic [15:0] run_length;
  logic        ends_line;
  logic        last;

  modport source (output valid, output char_class, output group_kind,
                  output run_length, output ends_line, output last, input ready);
  modport sink   (input valid, input char_class, input group_kind,
                  input run_length, input ends_line, input last, output ready);
endinterface

FILE: design/char_run_token_classifier.sv
// Top level of the character run classifier: run state, word matching and
// the result queue. Depends on crtc_pkg, crtc_char_if, crtc_group_if and
// crtc_result_fifo.
//
//   channel  | dir | word contents
//   ---------+-----+---------------------------------------------------
//   chars    | in  | ch (8), line_end (1)
//   groups   | out | char_class (3), group_kind (2), run_length (16),
//            |     | ends_line (1), last (1)
//
// At most one byte is taken per cycle, while chars.ready is high; its results
// enter the result queue at the next edge and wait behind any queued words.
// A byte can cause up to two words; chars.ready is high while the four-word
// result queue holds two words or fewer, so bytes go in one per cycle while the
// output drains one word per cycle and the bytes average one word or less.
// A stalled output fills the queue and holds chars.ready low until it drains.
// rst (synchronous) closes any open run and empties the queue.
module char_run_token_classifier #(
  parameter int MATCH_CHARS = crtc_pkg::MATCH_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  crtc_char_if.sink  chars,
  crtc_group_if.source groups
);
  import crtc_pkg::*;

  localparam int CIDX_W = $clog2(MATCH_CHARS);

  // Open run state.
  logic [7:0]           run_chars [MATCH_CHARS];
  logic [RUN_LEN_W-1:0] run_count;
  class_t               run_class;
  logic                 run_active;

  logic                 accept;
  class_t               cls;
  logic                 close_old;
  logic                 start_new;
  logic [RUN_LEN_W-1:0] base_count;
  logic [RUN_LEN_W-1:0] count_next;
  logic                 char_wr;
  logic [7:0]           chars_next [MATCH_CHARS];
  logic [WORD_MAX-1:0][7:0] old_word;
  logic [WORD_MAX-1:0][7:0] new_word;
  kind_t                old_kind;
  kind_t                new_kind;
  result_t              res_old;
  result_t              res_new;
  result_t              push0;
  logic [1:0]           push_count;
  result_t              head;
  logic                 head_valid;
  fifo_status_t         status;

  assign accept = chars.valid && chars.ready;
  assign chars.ready = status.room2;

  // Class of the byte and whether it closes the open run.
  always_comb begin
    cls        = classify(chars.ch);
    close_old  = run_active && (cls != run_class);
    start_new  = !run_active || close_old;
    base_count = start_new ? '0 : run_count;
    count_next = (base_count == '1) ? base_count : base_count + RUN_LEN_W'(1);
    char_wr    = (base_count < RUN_LEN_W'(MATCH_CHARS));
  end

  // Stored characters with this byte written in.
  always_comb begin
    for (int i = 0; i < MATCH_CHARS; i++) begin
      chars_next[i] = (char_wr && base_count[CIDX_W-1:0] == CIDX_W'(i)) ? chars.ch
                                                                        : run_chars[i];
    end
    for (int i = 0; i < WORD_MAX; i++) begin
      old_word[i] = run_chars[i];
      new_word[i] = chars_next[i];
    end
  end

  // Word matching for the closed run and for the run ending this line.
  always_comb begin
    old_kind = (run_count > RUN_LEN_W'(MATCH_CHARS)) ? KIND_GENERIC
                                                     : match_kind(old_word, run_count);
    new_kind = (count_next > RUN_LEN_W'(MATCH_CHARS)) ? KIND_GENERIC
                                                      : match_kind(new_word, count_next);
  end

  // Result words and how many of them this byte pushes.
  always_comb begin
    res_old.char_class = run_class;
    res_old.group_kind = old_kind;
    res_old.run_length = run_count;
    res_old.ends_line  = 1'b0;
    res_old.last       = !chars.line_end;
    res_new.char_class = cls;
    res_new.group_kind = new_kind;
    res_new.run_length = count_next;
    res_new.ends_line  = 1'b1;
    res_new.last       = 1'b1;
    push0      = close_old ? res_old : res_new;
    push_count = accept ? (2'(close_old) + 2'(chars.line_end)) : 2'd0;
  end

  // Run control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      run_count  <= '0;
      run_class  <= CLS_SPACE;
    end else if (accept) begin
      if (chars.line_end) begin
        run_active <= 1'b0;
        run_count  <= '0;
        run_class  <= CLS_SPACE;
      end else begin
        run_active <= 1'b1;
        run_count  <= count_next;
        run_class  <= cls;
      end
    end
  end

  // First characters of the open run.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MATCH_CHARS; i++) begin
        run_chars[i] <= chars_next[i];
      end
    end
  end

  crtc_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (push0),
    .push1      (res_new),
    .pop        (groups.ready),
    .head       (head),
    .head_valid (head_valid),
    .status     (status)
  );

  // Output word from the queue head.
  assign groups.valid      = head_valid;
  assign groups.char_class = head.char_class;
  assign groups.group_kind = head.group_kind;
  assign groups.run_length = head.run_length;
  assign groups.ends_line  = head.ends_line;
  assign groups.last       = head.last;

`ifndef SYNTHESIS
  // A byte is taken only when the queue can hold both of its possible words.
  a_room: assert property (@(posedge clk) disable iff (rst)
    accept |-> status.level <= RES_LEVEL_W'(RES_DEPTH - 2))
    else $error("byte accepted without room for two results");

  // A line end always closes the run.
  a_line_close: assert property (@(posedge clk) disable iff (rst)
    (accept && chars.line_end) |=> !run_active)
    else $error("run still open after line end");

  // An open run always holds at least one character.
  a_run_count: assert property (@(posedge clk) disable iff (rst)
    run_active |-> run_count != '0)
    else $error("open run with zero length");
`endif

endmodule

FILE: design/crtc_result_fifo.sv
// Small result queue that takes zero, one or two words per cycle and gives one
// per cycle while pop is high and it is not empty. Depends on crtc_pkg.
module crtc_result_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [1:0]              push_count,
  input  crtc_pkg::result_t       push0,
  input  crtc_pkg::result_t       push1,
  input  logic                    pop,
  output crtc_pkg::result_t       head,
  output logic                    head_valid,
  output crtc_pkg::fifo_status_t  status
);
  import crtc_pkg::*;

  result_t                entries [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr;
  logic [RES_PTR_W-1:0]   rd_ptr;
  logic [RES_LEVEL_W-1:0] level;
  logic [RES_LEVEL_W-1:0] level_next;
  logic                   do_pop;

  assign head_valid   = (level != '0);
  assign head         = entries[rd_ptr];
  assign do_pop       = pop && head_valid;
  assign status.level = level;
  assign status.room2 = (level <= RES_LEVEL_W'(RES_DEPTH - 2));

  // Level follows pushes and pops in the same cycle.
  always_comb begin
    level_next = level + RES_LEVEL_W'(push_count) - RES_LEVEL_W'(do_pop);
  end

  // Pointers and level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push_count);
      rd_ptr <= rd_ptr + RES_PTR_W'(do_pop);
      level  <= level_next;
    end
  end

  // Entry storage; the second word lands one place after the first.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + RES_PTR_W'(1)] <= push1;
    end
  end

endmodule
